// File: src/char_lcd_terminal_sequencer_macros.svh
// Assertion macros for the character display terminal sequencer.
// Used by the RTL files that carry assertions; no other dependencies.
`ifndef CHAR_LCD_TERMINAL_SEQUENCER_MACROS_SVH
`define CHAR_LCD_TERMINAL_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define CLT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond never holds
`define CLT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define CLT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define CLT_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: src/clt_pkg.sv
// Shared types, codes and tables of the character display terminal sequencer.
// No dependencies; used by the front end, queue, back end and top level.
package clt_pkg;

    localparam int COLUMNS_DEFAULT = 16;
    localparam int QUEUE_DEPTH     = 2;

    // terminal operation codes
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_HOME   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // display command bytes
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CURSOR_BLINK = 8'h0F;
    localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h10;
    localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h14;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_ROW0_HOME    = 8'h80;
    localparam logic [7:0] CMD_ROW1_HOME    = 8'hC0;

    // delay classes
    localparam logic [1:0] DLY_FAST  = 2'd0;
    localparam logic [1:0] DLY_SLOW  = 2'd1;
    localparam logic [1:0] DLY_START = 2'd2;

    // entry points into the fixed command table
    localparam logic [2:0] FIX_INIT  = 3'd0;
    localparam logic [2:0] FIX_CLEAR = 3'd3;
    localparam logic [2:0] FIX_HOME  = 3'd4;
    localparam logic [2:0] FIX_LAST  = 3'd4;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_RETURN,
        KIND_NEWLINE,
        KIND_BACKSPACE,
        KIND_CLEAR,
        KIND_HOME,
        KIND_CURSOR,
        KIND_INIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } q_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIXED,
        ST_SINGLE,
        ST_PLAIN,
        ST_RIGHT,
        ST_JUMP,
        ST_LEFT
    } seq_state_t;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_NL_RIGHT,
        MODE_NL_LEFT,
        MODE_BS
    } seq_mode_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic [1:0] delay_class;
    } fixed_wr_t;

    // init, clear and home share one command list
    function automatic fixed_wr_t fixed_write(input logic [2:0] idx);
        fixed_wr_t w;
        case (idx)
            3'd0:    w = '{bus_byte: CMD_FUNCTION_SET, delay_class: DLY_START};
            3'd1:    w = '{bus_byte: CMD_DISPLAY_ON,   delay_class: DLY_FAST};
            3'd2:    w = '{bus_byte: CMD_ENTRY_MODE,   delay_class: DLY_SLOW};
            3'd3:    w = '{bus_byte: CMD_CLEAR,        delay_class: DLY_SLOW};
            default: w = '{bus_byte: CMD_HOME,         delay_class: DLY_SLOW};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] row_home(input logic row);
        return row ? CMD_ROW1_HOME : CMD_ROW0_HOME;
    endfunction

endpackage

// File: src/clt_channels.sv
// Handshake channels of the terminal sequencer: operations in, display writes out.
// No dependencies.
interface term_op_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] character;
    logic       cursor_on;

    modport source (output valid, operation, character, cursor_on, input ready);
    modport sink   (input valid, operation, character, cursor_on, output ready);
endinterface

interface lcd_wr_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] bus_byte;
    logic [1:0] delay_class;
    logic       last;

    modport source (output valid, register_select, bus_byte, delay_class, last, input ready);
    modport sink   (input valid, register_select, bus_byte, delay_class, last, output ready);
endinterface

// File: src/clt_front.sv
// Front end: takes operation transfers and classifies them into queue commands.
// Depends on clt_pkg and term_op_if.
module clt_front (
    term_op_if.sink       term,
    input  logic          full,
    output clt_pkg::q_wr_t wr
);

    logic known;

    // classify; unknown operations are taken and dropped
    always_comb
    begin
        known       = 1'b1;
        wr.cmd.kind = clt_pkg::KIND_PLAIN;
        wr.cmd.data = term.character;
        case (term.operation)
            clt_pkg::OP_PUT:
            begin
                case (term.character)
                    clt_pkg::CH_RETURN:    wr.cmd.kind = clt_pkg::KIND_RETURN;
                    clt_pkg::CH_NEWLINE:   wr.cmd.kind = clt_pkg::KIND_NEWLINE;
                    clt_pkg::CH_BACKSPACE: wr.cmd.kind = clt_pkg::KIND_BACKSPACE;
                    default:               wr.cmd.kind = clt_pkg::KIND_PLAIN;
                endcase
            end
            clt_pkg::OP_CLEAR: wr.cmd.kind = clt_pkg::KIND_CLEAR;
            clt_pkg::OP_HOME:  wr.cmd.kind = clt_pkg::KIND_HOME;
            clt_pkg::OP_CURSOR:
            begin
                wr.cmd.kind = clt_pkg::KIND_CURSOR;
                wr.cmd.data = term.cursor_on ? clt_pkg::CMD_CURSOR_BLINK
                                             : clt_pkg::CMD_DISPLAY_ON;
            end
            clt_pkg::OP_INIT:  wr.cmd.kind = clt_pkg::KIND_INIT;
            default:           known = 1'b0;
        endcase
        wr.push = term.valid && !full && known;
    end

    // handshake
    assign term.ready = !full;

endmodule

// File: src/clt_queue.sv
// Short command queue between front and back ends.
// Depends on clt_pkg.
module clt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  clt_pkg::q_wr_t wr,
    output logic           full,
    input  logic           pop,
    output clt_pkg::q_rd_t rd
);

    localparam int DEPTH = clt_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    clt_pkg::cmd_t  entry_reg [DEPTH];
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [AW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign rd.avail = (count_reg != '0);
    assign rd.cmd   = entry_reg[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= wr.cmd;
        end
    end

endmodule

// File: src/clt_back.sv
// Back end: cursor tracking and write sequencer with an output register.
// Depends on clt_pkg, lcd_wr_if and the assertion macro header.
`include "char_lcd_terminal_sequencer_macros.svh"

module clt_back #(
    parameter int COLUMNS = clt_pkg::COLUMNS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  clt_pkg::q_rd_t rd,
    output logic           pop,
    lcd_wr_if.source       lcd
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int CNT_W = $clog2(COLUMNS + 1);
    localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLUMNS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0] CNT_RUN  = CNT_W'(COLUMNS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    clt_pkg::seq_state_t state_reg, state_next, nxt;
    clt_pkg::seq_mode_t  mode_reg, mode_next;
    clt_pkg::fixed_wr_t  fw;
    logic                bs_phase_reg, bs_phase_next;
    logic                jump_plain_reg, jump_plain_next;
    logic                row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    right_cnt_reg, right_cnt_next;
    logic [CNT_W-1:0]    left_cnt_reg, left_cnt_next;
    logic [2:0]          idx_reg, idx_next;
    logic [7:0]          data_reg, data_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_rs_reg;
    logic [7:0]          out_byte_reg;
    logic [1:0]          out_dly_reg;
    logic                out_last_reg;

    logic                emit, emit_ok, emit_rs, emit_last;
    logic [7:0]          emit_byte;
    logic [1:0]          emit_dly;

    // where a finished cursor-left step goes
    function automatic clt_pkg::seq_state_t after_left(input clt_pkg::seq_mode_t mode,
                                                       input logic phase,
                                                       input logic more);
        clt_pkg::seq_state_t s;
        s = clt_pkg::ST_IDLE;
        if (mode == clt_pkg::MODE_NL_LEFT && more)
        begin
            s = clt_pkg::ST_LEFT;
        end
        else if (mode == clt_pkg::MODE_BS && !phase)
        begin
            s = clt_pkg::ST_PLAIN;
        end
        return s;
    endfunction

    // where a finished run of cursor-right steps goes
    function automatic clt_pkg::seq_state_t after_run(input clt_pkg::seq_mode_t mode,
                                                      input logic phase,
                                                      input logic more);
        clt_pkg::seq_state_t s;
        s = clt_pkg::ST_IDLE;
        if (mode != clt_pkg::MODE_NL_RIGHT)
        begin
            s = after_left(mode, phase, more);
        end
        return s;
    endfunction

    // where a finished character write goes
    function automatic clt_pkg::seq_state_t after_plain(input clt_pkg::seq_mode_t mode);
        return (mode == clt_pkg::MODE_BS) ? clt_pkg::ST_LEFT : clt_pkg::ST_IDLE;
    endfunction

    assign emit_ok = !out_valid_reg || lcd.ready;
    assign fw      = clt_pkg::fixed_write(idx_reg);

    // sequencer: next state and write to emit
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        bs_phase_next   = bs_phase_reg;
        jump_plain_next = jump_plain_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        right_cnt_next  = right_cnt_reg;
        left_cnt_next   = left_cnt_reg;
        idx_next        = idx_reg;
        data_next       = data_reg;
        nxt             = clt_pkg::ST_IDLE;
        pop             = 1'b0;
        emit            = 1'b0;
        emit_rs         = 1'b0;
        emit_byte       = data_reg;
        emit_dly        = clt_pkg::DLY_FAST;
        emit_last       = 1'b0;

        case (state_reg)
            clt_pkg::ST_IDLE:
            begin
                if (rd.avail)
                begin
                    pop       = 1'b1;
                    data_next = rd.cmd.data;
                    case (rd.cmd.kind)
                        clt_pkg::KIND_PLAIN:
                        begin
                            mode_next  = clt_pkg::MODE_PLAIN;
                            state_next = clt_pkg::ST_PLAIN;
                        end
                        clt_pkg::KIND_RETURN:
                        begin
                            data_next  = clt_pkg::row_home(row_reg);
                            col_next   = '0;
                            state_next = clt_pkg::ST_SINGLE;
                        end
                        clt_pkg::KIND_NEWLINE:
                        begin
                            if (!row_reg)
                            begin
                                mode_next      = clt_pkg::MODE_NL_RIGHT;
                                right_cnt_next = CNT_FULL;
                                state_next     = clt_pkg::ST_RIGHT;
                            end
                            else
                            begin
                                mode_next     = clt_pkg::MODE_NL_LEFT;
                                left_cnt_next = CNT_FULL;
                                state_next    = clt_pkg::ST_LEFT;
                            end
                        end
                        clt_pkg::KIND_BACKSPACE:
                        begin
                            mode_next     = clt_pkg::MODE_BS;
                            bs_phase_next = 1'b0;
                            left_cnt_next = CNT_TWO;
                            data_next     = clt_pkg::CH_SPACE;
                            state_next    = clt_pkg::ST_LEFT;
                        end
                        clt_pkg::KIND_CLEAR:
                        begin
                            idx_next   = clt_pkg::FIX_CLEAR;
                            row_next   = 1'b0;
                            col_next   = '0;
                            state_next = clt_pkg::ST_FIXED;
                        end
                        clt_pkg::KIND_HOME:
                        begin
                            idx_next   = clt_pkg::FIX_HOME;
                            row_next   = 1'b0;
                            col_next   = '0;
                            state_next = clt_pkg::ST_FIXED;
                        end
                        clt_pkg::KIND_INIT:
                        begin
                            idx_next   = clt_pkg::FIX_INIT;
                            row_next   = 1'b0;
                            col_next   = '0;
                            state_next = clt_pkg::ST_FIXED;
                        end
                        clt_pkg::KIND_CURSOR:
                        begin
                            state_next = clt_pkg::ST_SINGLE;
                        end
                        default:
                        begin
                            state_next = clt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            clt_pkg::ST_FIXED:
            begin
                emit      = 1'b1;
                emit_byte = fw.bus_byte;
                emit_dly  = fw.delay_class;
                emit_last = (idx_reg == clt_pkg::FIX_LAST);
                if (emit_ok)
                begin
                    if (idx_reg == clt_pkg::FIX_LAST)
                    begin
                        state_next = clt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            clt_pkg::ST_SINGLE:
            begin
                emit      = 1'b1;
                emit_dly  = clt_pkg::DLY_SLOW;
                emit_last = 1'b1;
                if (emit_ok)
                begin
                    state_next = clt_pkg::ST_IDLE;
                end
            end

            clt_pkg::ST_PLAIN:
            begin
                emit    = 1'b1;
                emit_rs = 1'b1;
                if (col_reg == COL_MAX)
                begin
                    nxt = clt_pkg::ST_JUMP;
                end
                else
                begin
                    nxt = after_plain(mode_reg);
                end
                emit_last = (nxt == clt_pkg::ST_IDLE);
                if (emit_ok)
                begin
                    state_next      = nxt;
                    jump_plain_next = 1'b1;
                    bs_phase_next   = 1'b1;
                    if (col_reg != COL_MAX)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end

            clt_pkg::ST_RIGHT:
            begin
                emit      = 1'b1;
                emit_byte = clt_pkg::CMD_SHIFT_RIGHT;
                if (col_reg == COL_MAX)
                begin
                    nxt = clt_pkg::ST_JUMP;
                end
                else if (right_cnt_reg > CNT_ONE)
                begin
                    nxt = clt_pkg::ST_RIGHT;
                end
                else
                begin
                    nxt = after_run(mode_reg, bs_phase_reg, left_cnt_reg != '0);
                end
                emit_last = (nxt == clt_pkg::ST_IDLE);
                if (emit_ok)
                begin
                    state_next      = nxt;
                    jump_plain_next = 1'b0;
                    right_cnt_next  = right_cnt_reg - 1'b1;
                    if (col_reg != COL_MAX)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end

            clt_pkg::ST_JUMP:
            begin
                emit      = 1'b1;
                emit_byte = clt_pkg::row_home(!row_reg);
                emit_dly  = clt_pkg::DLY_SLOW;
                if (jump_plain_reg)
                begin
                    nxt = after_plain(mode_reg);
                end
                else if (right_cnt_reg != '0)
                begin
                    nxt = clt_pkg::ST_RIGHT;
                end
                else
                begin
                    nxt = after_run(mode_reg, bs_phase_reg, left_cnt_reg != '0);
                end
                emit_last = (nxt == clt_pkg::ST_IDLE);
                if (emit_ok)
                begin
                    state_next = nxt;
                    row_next   = !row_reg;
                    col_next   = '0;
                end
            end

            clt_pkg::ST_LEFT:
            begin
                emit = 1'b1;
                if (col_reg == '0)
                begin
                    // wrap back to the other row's end through a run of right steps
                    emit_byte = clt_pkg::row_home(!row_reg);
                    emit_dly  = clt_pkg::DLY_SLOW;
                    nxt       = clt_pkg::ST_RIGHT;
                end
                else
                begin
                    emit_byte = clt_pkg::CMD_SHIFT_LEFT;
                    nxt       = after_left(mode_reg, bs_phase_reg, left_cnt_reg > CNT_ONE);
                end
                emit_last = (nxt == clt_pkg::ST_IDLE);
                if (emit_ok)
                begin
                    state_next    = nxt;
                    left_cnt_next = left_cnt_reg - 1'b1;
                    if (col_reg == '0)
                    begin
                        row_next       = !row_reg;
                        right_cnt_next = CNT_RUN;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = clt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit && emit_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (lcd.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= clt_pkg::ST_IDLE;
            mode_reg       <= clt_pkg::MODE_PLAIN;
            bs_phase_reg   <= 1'b0;
            jump_plain_reg <= 1'b0;
            row_reg        <= 1'b0;
            col_reg        <= '0;
            right_cnt_reg  <= '0;
            left_cnt_reg   <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            bs_phase_reg   <= bs_phase_next;
            jump_plain_reg <= jump_plain_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            right_cnt_reg  <= right_cnt_next;
            left_cnt_reg   <= left_cnt_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (emit && emit_ok)
        begin
            out_rs_reg   <= emit_rs;
            out_byte_reg <= emit_byte;
            out_dly_reg  <= emit_dly;
            out_last_reg <= emit_last;
        end
    end

    assign lcd.valid           = out_valid_reg;
    assign lcd.register_select = out_rs_reg;
    assign lcd.bus_byte        = out_byte_reg;
    assign lcd.delay_class     = out_dly_reg;
    assign lcd.last            = out_last_reg;

    // checks
    `CLT_ASSERT_NEVER(a_col_range, clk, rst_n, col_reg > COL_MAX, "cursor column out of range")
    `CLT_ASSERT_NEVER(a_right_cnt, clk, rst_n, state_reg == clt_pkg::ST_RIGHT && right_cnt_reg == '0, "right run with no steps left")
    `CLT_ASSERT_NEXT(a_last_idle, clk, rst_n, emit && emit_ok && emit_last, state_reg == clt_pkg::ST_IDLE, "sequencer busy after final write")
    `CLT_ASSERT_IMPLIES(a_idle_out, clk, rst_n, state_reg == clt_pkg::ST_IDLE && out_valid_reg, out_last_reg, "idle with a non-final write pending")

endmodule

// File: src/char_lcd_terminal_sequencer.sv
// Terminal sequencer for a two-row character display: operations in, bus writes out.
// An operation's first write passes the queue, sequencer state and output register.
// Throughput: one write per cycle within an operation while lcd.ready holds; the back
// end takes the next operation once idle; backspace at a row start is the longest one.
// Reset: asynchronous, active low; cursor at row 0 column 0, queue and output empty.
// Depends on clt_pkg, clt_channels, clt_front, clt_queue and clt_back.
module char_lcd_terminal_sequencer #(
    parameter int COLUMNS = clt_pkg::COLUMNS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    term_op_if.sink  term,
    lcd_wr_if.source lcd
);

    clt_pkg::q_wr_t q_wr;
    clt_pkg::q_rd_t q_rd;
    logic           q_full;
    logic           q_pop;

    // classify operations
    clt_front u_front (
        .term (term),
        .full (q_full),
        .wr   (q_wr)
    );

    // decouple front and back
    clt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    // generate display writes
    clt_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (q_rd),
        .pop   (q_pop),
        .lcd   (lcd)
    );

endmodule
